>>> rtl/lvf_pkg.sv
package lvf_pkg;

	localparam int PIX_W     = 8;
	localparam int LW_W      = 11;
	localparam int NORM_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORM         = 2'd2;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

endpackage

>>> rtl/lvf_store.sv
module lvf_store
	import lvf_pkg::*;
#(
	parameter int DEPTH = 2051,
	parameter int AW    = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [PIX_W-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/lvf_div.sv
module lvf_div
	import lvf_pkg::*;
#(
	parameter int DW = 22
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DW-1:0]     dividend,
	input  logic [NORM_W-1:0] divisor,
	output logic              done,
	output logic [DW-1:0]     quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [NORM_W-1:0] rem_q;
	logic [NORM_W-1:0] div_q;
	logic [DW-1:0]     dq_q;
	logic [NORM_W:0]   trial;
	logic [NORM_W:0]   diff;
	logic              ge;

	// shift one dividend bit into the remainder, subtract where it fits
	assign trial = {rem_q, dq_q[DW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[NORM_W-1:0] : trial[NORM_W-1:0];
			dq_q  <= {dq_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

>>> rtl/local_variance_filter.sv
// Local variance filter.
// Input channel s_axis: one grey pixel per item in raster order; tuser set
// marks a drain item that carries no pixel. Output channel m_axis: one
// filtered pixel per result, tuser the underflow flag, tlast on the frame's
// last pixel. Results lag the input by RADIUS rows plus RADIUS pixels, so
// drain items push out the tail of a frame.
// Configuration channel cfg: index 0 line width, 1 frame height, 2 norm;
// a write to a listed register restarts the frame and closes the input
// while it lands. Write registers only while no item is in flight.
// Flow: an item that yields no result is taken and the input stays open. A
// border pixel closes the input while it passes S_BRD, S_BRDD and S_OUT. An
// interior pixel reads its (2R+1)^2 window one entry a cycle from the delay
// memory, divides both sums by the window count with reciprocal multiplies,
// then divides the variance by norm on a bit-serial divider before S_OUT.
// Reset clears positions and control; the delay memory is not cleared, the
// frame logic reads only entries written earlier in the same frame.
// A stalled receiver holds the result register; the next item is still
// taken and worked on, and its result waits until the register frees.
module local_variance_filter
	import lvf_pkg::*;
#(
	parameter int RADIUS     = 1,
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] pixel
	input  logic                 s_axis_tuser,  // [0] flush
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,  // [7:0] out_pixel
	output logic                 m_axis_tuser,  // [0] underflow
	output logic                 m_axis_tlast,  // frame_last
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NORM_W-1:0]    cfg_data
);

	localparam int SIDE   = 2 * RADIUS + 1;
	localparam int NWIN   = SIDE * SIDE;
	localparam int RING   = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
	localparam int AW     = $clog2(RING);
	localparam int OW     = AW + 3;
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int S1_W   = $clog2(NWIN * 255 + 1);
	localparam int S2_W   = $clog2(NWIN * 65025 + 1);
	localparam int DXW    = $clog2(SIDE + 1);
	// reciprocal of the window count, exact floor for any sum below 2^S2_W
	localparam int RSH    = S2_W + $clog2(NWIN);
	localparam int RCP_W  = S2_W + 1;
	localparam longint RECIP = ((longint'(1) << RSH) + longint'(NWIN) - 1) / longint'(NWIN);
	localparam logic [RCP_W-1:0] RCP = RCP_W'(RECIP);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_WIN   = 10'b0000000010,
		S_DRAIN = 10'b0000000100,
		S_DIV2  = 10'b0000001000,
		S_DIV1  = 10'b0000010000,
		S_MUL   = 10'b0000100000,
		S_DIVQ  = 10'b0001000000,
		S_BRD   = 10'b0010000000,
		S_BRDD  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [LW_W-1:0]   line_width_q;
	logic [LW_W-1:0]   frame_height_q;
	logic [NORM_W-1:0] norm_q;
	logic              dirty_q;

	logic [WW-1:0]     eff_w;
	logic [HW-1:0]     eff_h;
	logic [POS_W-1:0]  total_q;
	logic [POS_W-1:0]  lag_q;

	logic [POS_W-1:0]  in_pos_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [AW-1:0]     wr_q;
	logic [AW-1:0]     rd_q;

	logic signed [OW-1:0] off_q;
	logic [DXW-1:0]    dx_q;
	logic [DXW-1:0]    dy_q;
	logic              rd_v_s1;
	logic [S1_W-1:0]   s1_q;
	logic [S2_W-1:0]   s2_q;
	logic [S2_W-1:0]   sqm_q;
	logic [PIX_W-1:0]  mean_q;
	logic [S2_W-1:0]   var_q;
	logic              div_go_q;

	logic [PIX_W-1:0]  res_pix_q;
	logic              res_uf_q;

	logic              out_v_q;
	logic [PIX_W-1:0]  out_pix_q;
	logic              out_uf_q;
	logic              out_last_q;

	logic              in_acc;
	logic              take_pix;
	logic              emit_now;
	logic              interior;
	logic [POS_W:0]    fill;
	logic              wr_en;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     win_addr;
	logic signed [OW-1:0] addr_sum;
	logic [PIX_W-1:0]  rdata;
	logic [S2_W-1:0]   rcp_arg;
	logic [S2_W+RCP_W-1:0] rcp_prod;
	logic [S2_W-1:0]   rcp_quot;
	logic              div_done;
	logic [S2_W-1:0]   div_quot;
	logic              out_free;
	logic              frame_end;
	logic [NORM_W-1:0] norm_eff;
	logic              cfg_restart;

	// clamp the geometry to what the store can hold
	always_comb begin
		int lw;
		int fh;
		lw = int'(line_width_q);
		fh = int'(frame_height_q);
		if (lw < 1) lw = 1;
		if (lw > MAX_WIDTH) lw = MAX_WIDTH;
		if (fh < 1) fh = 1;
		if (fh > MAX_HEIGHT) fh = MAX_HEIGHT;
		eff_w = WW'(lw);
		eff_h = HW'(fh);
	end

	assign norm_eff = (norm_q == '0) ? NORM_W'(1) : norm_q;

	always_ff @(posedge clk) begin
		total_q <= POS_W'(eff_w) * POS_W'(eff_h);
		lag_q   <= POS_W'(RADIUS) * POS_W'(eff_w) + POS_W'(RADIUS);
	end

	assign cfg_ready     = 1'b1;
	assign cfg_restart   = (cfg_index == REG_LINE_WIDTH) || (cfg_index == REG_FRAME_HEIGHT) ||
	                       (cfg_index == REG_NORM);
	// hold the input off while a register write lands
	assign s_axis_tready = (state_q == S_IDLE) && !dirty_q && !cfg_valid;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign take_pix = !s_axis_tuser && (in_pos_q < total_q);
	assign fill     = {1'b0, in_pos_q} + 1'b1 - {1'b0, out_pos_q};
	assign emit_now = take_pix ? (fill > {1'b0, lag_q})
	                           : ((in_pos_q >= total_q) && (out_pos_q < total_q));
	assign interior = (out_pos_q >= lag_q) &&
	                  ({1'b0, out_pos_q} + {1'b0, lag_q} < {1'b0, total_q});
	assign wr_en    = in_acc && take_pix;

	// window entry address: output position plus signed offset, wrapped
	assign addr_sum = $signed({{(OW-AW){1'b0}}, rd_q}) + off_q;
	always_comb begin
		if (addr_sum < 0) begin
			win_addr = AW'(addr_sum + OW'(RING));
		end else if (addr_sum >= OW'(RING)) begin
			win_addr = AW'(addr_sum - OW'(RING));
		end else begin
			win_addr = AW'(addr_sum);
		end
	end
	assign raddr = (state_q == S_WIN) ? win_addr : rd_q;

	lvf_store #(
		.DEPTH(RING),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_q),
		.wdata(s_axis_tdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// divide by the window count: sum of squares first, then the plain sum
	assign rcp_arg  = (state_q == S_DIV1) ? S2_W'(s1_q) : s2_q;
	assign rcp_prod = {{RCP_W{1'b0}}, rcp_arg} * {{S2_W{1'b0}}, RCP};
	assign rcp_quot = S2_W'(rcp_prod >> RSH);

	lvf_div #(
		.DW(S2_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_go_q),
		.dividend(var_q),
		.divisor (norm_eff),
		.done    (div_done),
		.quotient(div_quot)
	);

	assign out_free  = !out_v_q || m_axis_tready;
	assign frame_end = ({1'b0, out_pos_q} + 1'b1) >= {1'b0, total_q};

	// control: sequencer, positions, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			line_width_q   <= LW_W'(640);
			frame_height_q <= LW_W'(480);
			norm_q         <= NORM_W'(1);
			dirty_q        <= 1'b1;
			in_pos_q       <= '0;
			out_pos_q      <= '0;
			wr_q           <= '0;
			rd_q           <= '0;
			rd_v_s1        <= 1'b0;
			div_go_q       <= 1'b0;
			out_v_q        <= 1'b0;
		end else begin
			dirty_q  <= cfg_valid && cfg_restart;
			div_go_q <= (state_q == S_MUL);
			rd_v_s1  <= (state_q == S_WIN);
			if (state_q == S_OUT && out_free) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end

			if (cfg_valid) begin
				case (cfg_index)
					REG_LINE_WIDTH: line_width_q <= cfg_data[LW_W-1:0];
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data[LW_W-1:0];
					REG_NORM: norm_q <= cfg_data;
					default: ;
				endcase
			end

			if (cfg_valid && cfg_restart) begin
				in_pos_q  <= '0;
				out_pos_q <= '0;
				wr_q      <= '0;
				rd_q      <= '0;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (in_acc) begin
							if (take_pix) begin
								in_pos_q <= in_pos_q + 1'b1;
								wr_q     <= (wr_q == AW'(RING - 1)) ? '0 : wr_q + 1'b1;
							end
							if (emit_now) begin
								state_q <= interior ? S_WIN : S_BRD;
							end
						end
					end
					S_WIN: begin
						if (dx_q == DXW'(SIDE - 1) && dy_q == DXW'(SIDE - 1)) begin
							state_q <= S_DRAIN;
						end
					end
					S_DRAIN: state_q <= S_DIV2;
					S_DIV2: state_q <= S_DIV1;
					S_DIV1: state_q <= S_MUL;
					S_MUL: state_q <= S_DIVQ;
					S_DIVQ: begin
						if (div_done) begin
							state_q <= S_OUT;
						end
					end
					S_BRD: state_q <= S_BRDD;
					S_BRDD: state_q <= S_OUT;
					S_OUT: begin
						if (out_free) begin
							state_q <= S_IDLE;
							if (frame_end) begin
								in_pos_q  <= '0;
								out_pos_q <= '0;
								wr_q      <= '0;
								rd_q      <= '0;
							end else begin
								out_pos_q <= out_pos_q + 1'b1;
								rd_q      <= (rd_q == AW'(RING - 1)) ? '0 : rd_q + 1'b1;
							end
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// datapath: window walk, sums, quotients, result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			off_q <= -$signed({{(OW-AW){1'b0}}, lag_q[AW-1:0]});
			dx_q  <= '0;
			dy_q  <= '0;
			s1_q  <= '0;
			s2_q  <= '0;
		end else if (state_q == S_WIN) begin
			if (dx_q == DXW'(SIDE - 1)) begin
				dx_q  <= '0;
				dy_q  <= dy_q + 1'b1;
				off_q <= off_q + $signed({{(OW-WW){1'b0}}, eff_w}) - OW'(2 * RADIUS);
			end else begin
				dx_q  <= dx_q + 1'b1;
				off_q <= off_q + OW'(1);
			end
		end
		if (rd_v_s1) begin
			s1_q <= s1_q + S1_W'(rdata);
			s2_q <= s2_q + S2_W'(rdata) * S2_W'(rdata);
		end
		if (state_q == S_DIV2) begin
			sqm_q <= rcp_quot;
		end
		if (state_q == S_DIV1) begin
			mean_q <= rcp_quot[PIX_W-1:0];
		end
		if (state_q == S_MUL) begin
			var_q <= sqm_q - S2_W'(mean_q) * S2_W'(mean_q);
		end
		if (state_q == S_DIVQ && div_done) begin
			res_pix_q <= PIX_MAX - div_quot[PIX_W-1:0];
			res_uf_q  <= |div_quot[S2_W-1:PIX_W];
		end
		if (state_q == S_BRDD) begin
			res_pix_q <= rdata;
			res_uf_q  <= 1'b0;
		end
		if (state_q == S_OUT && out_free) begin
			out_pix_q  <= res_pix_q;
			out_uf_q   <= res_uf_q;
			out_last_q <= ({1'b0, out_pos_q} + 1'b1) == {1'b0, total_q};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_pix_q;
	assign m_axis_tuser  = out_uf_q;
	assign m_axis_tlast  = out_last_q;

endmodule

>>> verif/lvf_checker.sv
`timescale 1ns / 100ps

// Watches the pixel, result and register channels of the local variance filter.
// Keeps its own copy of the frame state, predicts each output pixel and compares.
module lvf_checker
	import lvf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,
	input  logic                 s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [7:0]           m_axis_tdata,
	input  logic                 m_axis_tuser,
	input  logic                 m_axis_tlast,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [NORM_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	localparam int RAD   = 1;
	localparam int MAXW  = 1024;
	localparam int MAXH  = 1024;
	localparam int SIDE  = 2 * RAD + 1;
	localparam int AREA  = SIDE * SIDE;
	localparam int DEPTH = 2 * RAD * MAXW + 2 * RAD + 1;

	typedef struct packed {
		logic [7:0] px;
		logic       uf;
		logic       last;
	} out_pix_t;

	logic [7:0]        pix_ring [DEPTH];
	logic [LW_W-1:0]   line_w;
	logic [LW_W-1:0]   rows;
	logic [NORM_W-1:0] divisor;
	int unsigned       wr_pos;
	int unsigned       rd_pos;
	out_pix_t          pix_queue [$];

	assign outstanding = pix_queue.size();

	function automatic int unsigned clamp(input int unsigned v, input int unsigned hi);
		if (v < 1)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// produce the output pixel at the read position and advance it
	task automatic emit_pixel(input int unsigned total, input int unsigned lag,
			input int unsigned w);
		out_pix_t    r;
		int unsigned s1, s2, v, mean, var_q, q, base;
		r.uf = 1'b0;
		if (rd_pos >= lag && rd_pos + lag < total) begin
			s1 = 0;
			s2 = 0;
			base = rd_pos - lag;
			for (int dy = 0; dy < SIDE; dy++)
				for (int dx = 0; dx < SIDE; dx++) begin
					v = pix_ring[(base + dx + dy * w) % DEPTH];
					s1 += v;
					s2 += v * v;
				end
			mean  = s1 / AREA;
			var_q = s2 / AREA - mean * mean;
			q     = var_q / ((divisor == 0) ? 1 : divisor);
			r.uf  = (q > 255);
			r.px  = 8'(255 - q);
		end else begin
			r.px = pix_ring[rd_pos % DEPTH];
		end
		r.last = (rd_pos + 1 == total);
		pix_queue.push_back(r);
		rd_pos++;
		if (rd_pos >= total) begin
			rd_pos = 0;
			wr_pos = 0;
		end
	endtask

	task automatic take_item(input logic [7:0] pix, input logic drain);
		int unsigned w, total, lag;
		w     = clamp(line_w, MAXW);
		total = w * clamp(rows, MAXH);
		lag   = RAD * w + RAD;
		if (wr_pos < total && !drain) begin
			pix_ring[wr_pos % DEPTH] = pix;
			wr_pos++;
			if (wr_pos - rd_pos > lag)
				emit_pixel(total, lag, w);
		end else if (wr_pos >= total && rd_pos < total) begin
			emit_pixel(total, lag, w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_pix_t e;
		if (!arst_n) begin
			line_w     <= 11'd640;
			rows       <= 11'd480;
			divisor    <= 16'd1;
			wr_pos     = 0;
			rd_pos     = 0;
			mismatches <= 0;
			pix_queue.delete();
			for (int i = 0; i < DEPTH; i++)
				pix_ring[i] = '0;
		end else begin
			// results first: an item taken at this edge cannot have left already
			if (m_axis_tvalid && m_axis_tready) begin
				if (pix_queue.size() == 0) begin
					$display("%t: unexpected pixel %0d uf %0b last %0b", $time,
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					mismatches <= mismatches + 1;
				end else begin
					e = pix_queue.pop_front();
					if (e.px !== m_axis_tdata || e.uf !== m_axis_tuser
							|| e.last !== m_axis_tlast) begin
						$display("%t: expected pixel %0d uf %0b last %0b, got %0d %0b %0b",
							$time, e.px, e.uf, e.last,
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_item(s_axis_tdata, s_axis_tuser);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LINE_WIDTH: begin
						line_w <= cfg_data[LW_W-1:0];
						wr_pos = 0;
						rd_pos = 0;
					end
					REG_FRAME_HEIGHT: begin
						rows <= cfg_data[LW_W-1:0];
						wr_pos = 0;
						rd_pos = 0;
					end
					REG_NORM: begin
						divisor <= cfg_data;
						wr_pos = 0;
						rd_pos = 0;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
	import lvf_pkg::*;

	// index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	// watchdog: cycles without any handshake before the run is abandoned
	localparam int STALL_LIMIT = 6000;
	// quiet time before a register write, covers an interior pixel in flight
	localparam int SETTLE = 150;
	// long receiver hold-off, well beyond what the block can buffer
	localparam int LONG_HOLD = 700;
	localparam int TOTAL_ITEMS = 1100;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;   // [7:0] pixel
	logic                 s_axis_tuser;   // [0] flush
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [7:0]           m_axis_tdata;   // [7:0] out_pixel
	logic                 m_axis_tuser;   // [0] underflow
	logic                 m_axis_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [NORM_W-1:0]    cfg_data;

	int mismatches;
	int outstanding;
	int sent_items;
	int got_pixels;
	bit no_gaps;      // phase without idling on either side
	int idle_cycles;

	local_variance_filter dut (.*);

	lvf_checker chk (.*);

	always #2 clk = ~clk;

	// watchdog: count edges at which no channel moves an item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold-off once the stream is running
	initial begin
		int  gap;
		bit  held;
		held = 0;
		@(posedge arst_n);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 18);
			if (!held && got_pixels >= 60) begin
				gap  = LONG_HOLD;
				held = 1;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got_pixels++;
		end
	end

	// offer one item after a random gap and hold it until taken
	task automatic send_item(input logic [7:0] pix, input logic drain);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		s_axis_tuser  <= drain;
		do @(posedge clk); while (!s_axis_tready);
		sent_items++;
	endtask

	// drain everything expected, let the block settle, then write a register
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NORM_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_frame(input int w, input int h, input int nv);
		write_reg(REG_LINE_WIDTH, 16'(w));
		write_reg(REG_FRAME_HEIGHT, 16'(h));
		write_reg(REG_NORM, 16'(nv));
	endtask

	// mostly random greys, a quarter black or white, a tenth drain items
	task automatic send_random(input int count);
		logic [7:0] pix;
		for (int i = 0; i < count; i++) begin
			pix = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
				: 8'($urandom_range(0, 255));
			send_item(pix, $urandom_range(0, 9) == 0);
		end
	endtask

	// one full 3x3 frame with a single interior pixel, then drain and extras
	task automatic tiny_frame;
		for (int i = 0; i < 9; i++)
			send_item((i % 2) ? 8'h00 : 8'hFF, 1'b0);
		send_item(8'h5A, 1'b0);      // pixel past the frame end drains
		repeat (4) send_item(8'h00, 1'b1);
	endtask

	initial begin
		int w, h, nv, tot, lag, cnt;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_LINE_WIDTH;
		cfg_data      = '0;
		no_gaps       = 0;
		sent_items    = 0;
		got_pixels    = 0;
		idle_cycles   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: smallest frame with an interior pixel, drain ignored before frame end and when empty
		set_frame(3, 3, 1);
		send_item(8'hFF, 1'b1);
		tiny_frame();
		send_item(8'h00, 1'b1);
		// norm zero counts as one, largest norm
		write_reg(REG_NORM, 16'd0);
		tiny_frame();
		write_reg(REG_NORM, 16'hFFFF);
		tiny_frame();

		// a mid-sized frame that runs into the long receiver hold-off
		set_frame(20, 6, 4);
		send_random(20 * 6 + 40);
		// a short frame with no idling on either side
		set_frame(8, 5, 1);
		no_gaps = 1;
		send_random(8 * 5 + 20);
		no_gaps = 0;

		// random frames; unused index, clamped sizes and restarts mixed in
		write_reg(REG_SPARE, 16'(5));
		while (sent_items < TOTAL_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin w = $urandom_range(0, 2);    h = $urandom_range(0, 12); end
				1: begin w = $urandom_range(1025, 2047); h = $urandom_range(0, 1); end
				2: begin w = $urandom_range(3, 12);   h = $urandom_range(0, 2); end
				default: begin w = $urandom_range(3, 10); h = $urandom_range(3, 8); end
			endcase
			case ($urandom_range(0, 4))
				0:       nv = $urandom_range(0, 65535);
				1:       nv = $urandom_range(2, 64);
				default: nv = 1;
			endcase
			set_frame(w, h, nv);
			no_gaps = ($urandom_range(0, 4) == 0);
			w   = (w < 1) ? 1 : (w > 1024 ? 1024 : w);
			h   = (h < 1) ? 1 : h;
			tot = w * h;
			lag = w + 1;
			// clamped wide rows: a short start of the frame, cut off by the next write
			if (w == 1024)
				cnt = $urandom_range(1, 40);
			else
				cnt = tot + lag + $urandom_range(0, tot);
			send_random(cnt);
			no_gaps = 0;
		end
		s_axis_tvalid <= 1'b0;

		// wait for the tail, then allow the block to go quiet
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
